// File: src/matrix_multiply_engine_macros.svh
// Assertion macros shared by the matrix multiply engine RTL.
// No dependencies; the assertion forms are dropped when SYNTHESIS is defined.
`ifndef MATRIX_MULTIPLY_ENGINE_MACROS_SVH
`define MATRIX_MULTIPLY_ENGINE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define MME_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mme assertion failed");
// Next-cycle implication, disabled during reset.
`define MME_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mme assertion failed");
`else
`define MME_ASSERT_NOW(label, clk, rst, ante, cons)
`define MME_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: src/mme_pkg.sv
// Types and constants of the matrix multiply engine.
// No dependencies; used by mme_cell, mme_rsp_fifo and matrix_multiply_engine.
package mme_pkg;
   localparam int DIM_W      = 4;
   localparam int IDX_W      = 3;
   localparam int DATA_W     = 32;
   localparam int PROD_W     = 64;
   localparam int SUM_W      = 52;
   localparam int DIM_LIMIT  = 8;
   localparam int FIFO_DEPTH = 64;
   localparam int FIFO_PTR_W = 6;
   localparam int FIFO_CNT_W = 7;
   localparam int CSR_IDX_W  = 2;

   localparam logic [1:0] OP_WRITE_A = 2'd0;
   localparam logic [1:0] OP_WRITE_B = 2'd1;
   localparam logic [1:0] OP_COMPUTE = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_A    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INNER_DIM = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_B    = 2'd2;

   typedef struct packed {
      logic                     valid;
      logic [IDX_W-1:0]         tag;
      logic signed [DATA_W-1:0] a;
      logic signed [DATA_W-1:0] b;
   } bcast_type;

   typedef struct packed {
      logic                    valid;
      logic [IDX_W-1:0]        row;
      logic [IDX_W-1:0]        col;
      logic                    last;
      logic signed [SUM_W-1:0] sum;
   } word_type;

   typedef struct packed {
      logic [IDX_W-1:0]         row;
      logic [IDX_W-1:0]         col;
      logic signed [DATA_W-1:0] value;
      logic                     last;
   } rsp_word_type;

   typedef struct packed {
      logic full;
      logic idle;
   } fifo_status_type;
endpackage

// File: src/mme_req_if.sv
// Request channel of the matrix multiply engine: valid, ready and one input word.
// No dependencies.
interface mme_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         opcode;
   logic [2:0]         row_index;
   logic [2:0]         col_index;
   logic signed [31:0] element_value;
   modport source (output valid, opcode, row_index, col_index, element_value, input ready);
   modport sink (input valid, opcode, row_index, col_index, element_value, output ready);
endinterface

// File: src/mme_rsp_if.sv
// Response channel of the matrix multiply engine: valid, ready and one result word.
// No dependencies.
interface mme_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         out_row;
   logic [2:0]         out_col;
   logic signed [31:0] out_value;
   logic               last;
   modport source (output valid, out_row, out_col, out_value, last, input ready);
   modport sink (input valid, out_row, out_col, out_value, last, output ready);
endinterface

// File: src/mme_cell.sv
// One accumulate cell of the dot-product chain.
// Depends on mme_pkg.
module mme_cell #(
   parameter int CELL_IDX = 0
) (
   input  logic                        clock,
   input  logic                        reset,
   input  mme_pkg::bcast_type          bcast,
   input  logic [mme_pkg::DIM_W-1:0]   inner_dim,
   input  mme_pkg::word_type           prev_word,
   output mme_pkg::word_type           next_word
);
   import mme_pkg::*;

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [PROD_W-1:0] shifted;
   logic signed [SUM_W-1:0]  term;
   word_type                 word_ff, word_in;
   logic                     cell_on;

   assign cell_on = inner_dim > DIM_W'(CELL_IDX);

   always_comb begin
      prod_in = prod_ff;
      // capture the product meant for this cell
      if (bcast.valid && bcast.tag == IDX_W'(CELL_IDX)) begin
         prod_in = bcast.a * bcast.b;
      end
      shifted = prod_ff >>> 16;
      term    = cell_on ? SUM_W'(shifted) : '0;
      word_in     = prev_word;
      word_in.sum = prev_word.sum + term;
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (reset) begin
         word_ff <= '0;
      end else begin
         word_ff <= word_in;
      end
   end

   assign next_word = word_ff;
endmodule

// File: src/mme_rsp_fifo.sv
// Result queue with a registered output stage, deep enough for a whole result matrix.
// Depends on mme_pkg and mme_rsp_if.
module mme_rsp_fifo (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  mme_pkg::rsp_word_type     push_word,
   output mme_pkg::fifo_status_type  status,
   mme_rsp_if.source                 rsp_ch
);
   import mme_pkg::*;

   rsp_word_type            mem [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]   count_ff, count_in;
   logic                    out_valid_ff, out_valid_in;
   rsp_word_type            out_ff;
   logic                    pop;

   always_comb begin
      pop          = (count_ff != '0) && (!out_valid_ff || rsp_ch.ready);
      wr_ptr_in    = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in    = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in     = count_ff + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
      out_valid_in = pop || (out_valid_ff && !rsp_ch.ready);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_word;
      end
      if (pop) begin
         out_ff <= mem[rd_ptr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign status.full      = count_ff == FIFO_CNT_W'(FIFO_DEPTH);
   assign status.idle      = (count_ff == '0) && !out_valid_ff;
   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.out_row   = out_ff.row;
   assign rsp_ch.out_col   = out_ff.col;
   assign rsp_ch.out_value = out_ff.value;
   assign rsp_ch.last      = out_ff.last;
endmodule

// File: src/matrix_multiply_engine.sv
// Matrix multiply engine: loads are taken one word per cycle, back to back, while the request
// side is open. A compute walks one inner term per cycle, set by the single read port of each
// element store, and gives one result word per row and column of the product.
// Reset (synchronous, active high) sets all three dimensions to 8 and empties the
// chain and queue; the element stores are not cleared.
`include "matrix_multiply_engine_macros.svh"
module matrix_multiply_engine #(
   parameter int MAX_DIM = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   mme_req_if.sink                          req_ch,
   mme_rsp_if.source                        rsp_ch,
   input  logic                             csr_we,
   input  logic [mme_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [mme_pkg::DIM_W-1:0]        csr_data
);
   import mme_pkg::*;

   localparam int DIM_CAP = (MAX_DIM < DIM_LIMIT) ? MAX_DIM : DIM_LIMIT;
   localparam int DEPTH   = MAX_DIM * MAX_DIM;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int INF_W   = $clog2(DIM_CAP + 4) + 1;

   // dimension registers
   logic [DIM_W-1:0] rows_a_ff, inner_dim_ff, cols_b_ff;
   logic [DIM_W-1:0] nr, nk, nc;

   // sequencer
   logic             seq_active_ff;
   logic [IDX_W-1:0] i_ff, j_ff, k_ff;
   logic             issue, start, last_elem;
   logic             k_end, j_end, i_end;

   // element stores
   logic signed [DATA_W-1:0] a_mem [DEPTH];
   logic signed [DATA_W-1:0] b_mem [DEPTH];
   logic signed [DATA_W-1:0] a_rd_ff, b_rd_ff;
   logic [ADDR_W-1:0]        wr_addr, a_rd_addr, b_rd_addr;
   logic                     wr_ok, accept;

   // broadcast and chain head
   logic             bval_ff;
   logic [IDX_W-1:0] tag_ff;
   bcast_type        bcast;
   word_type         start_d1_ff, head_ff;
   word_type         chain [DIM_CAP+1];
   word_type         tail;

   // result side
   rsp_word_type     push_word;
   fifo_status_type  fifo_status;
   logic [INF_W-1:0] inflight_ff, inflight_in;
   logic             fits;

   // Treat zero as one and clip at the chain length.
   function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
      logic [DIM_W-1:0] r;
      r = d;
      if (d == '0) begin
         r = DIM_W'(1);
      end else if (d > DIM_W'(DIM_CAP)) begin
         r = DIM_W'(DIM_CAP);
      end
      return r;
   endfunction

   assign nr = eff_dim(rows_a_ff);
   assign nk = eff_dim(inner_dim_ff);
   assign nc = eff_dim(cols_b_ff);

   // Hold the request side while a compute is under way, words are in the chain or results are still queued.
   assign req_ch.ready = !seq_active_ff && (inflight_ff == '0) && fifo_status.idle;
   assign accept       = req_ch.valid && req_ch.ready;

   assign wr_ok   = (int'(req_ch.row_index) < MAX_DIM) && (int'(req_ch.col_index) < MAX_DIM);
   assign wr_addr = ADDR_W'(int'(req_ch.row_index) * MAX_DIM + int'(req_ch.col_index));

   // One inner term per cycle: A(i,k) and B(k,j).
   assign a_rd_addr = ADDR_W'(int'(i_ff) * MAX_DIM + int'(k_ff));
   assign b_rd_addr = ADDR_W'(int'(k_ff) * MAX_DIM + int'(j_ff));

   assign issue     = seq_active_ff;
   assign start     = issue && (k_ff == '0);
   assign k_end     = {1'b0, k_ff} == nk - 1'b1;
   assign j_end     = {1'b0, j_ff} == nc - 1'b1;
   assign i_end     = {1'b0, i_ff} == nr - 1'b1;
   assign last_elem = i_end && j_end;

   always_ff @(posedge clock) begin
      if (accept && wr_ok && req_ch.opcode == OP_WRITE_A) begin
         a_mem[wr_addr] <= req_ch.element_value;
      end
      if (accept && wr_ok && req_ch.opcode == OP_WRITE_B) begin
         b_mem[wr_addr] <= req_ch.element_value;
      end
      a_rd_ff <= a_mem[a_rd_addr];
      b_rd_ff <= b_mem[b_rd_addr];
      tag_ff  <= k_ff;
   end

   // Configuration and the i/j/k walk.
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_a_ff     <= DIM_W'(8);
         inner_dim_ff  <= DIM_W'(8);
         cols_b_ff     <= DIM_W'(8);
         seq_active_ff <= 1'b0;
         i_ff          <= '0;
         j_ff          <= '0;
         k_ff          <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_ROWS_A:    rows_a_ff    <= csr_data;
               CSR_INNER_DIM: inner_dim_ff <= csr_data;
               CSR_COLS_B:    cols_b_ff    <= csr_data;
               default:       ;
            endcase
         end
         if (accept && req_ch.opcode == OP_COMPUTE) begin
            seq_active_ff <= 1'b1;
            i_ff          <= '0;
            j_ff          <= '0;
            k_ff          <= '0;
         end else if (seq_active_ff) begin
            // advance k, then column, then row; drop out after the last term
            if (!k_end) begin
               k_ff <= k_ff + 1'b1;
            end else begin
               k_ff <= '0;
               if (!j_end) begin
                  j_ff <= j_ff + 1'b1;
               end else begin
                  j_ff <= '0;
                  if (!i_end) begin
                     i_ff <= i_ff + 1'b1;
                  end else begin
                     seq_active_ff <= 1'b0;
                  end
               end
            end
         end
      end
   end

   // Each word passes start_d1_ff and then head_ff to enter the chain head, just as cell 0
   // holds the product of its first term.
   always_ff @(posedge clock) begin
      if (reset) begin
         start_d1_ff <= '0;
         head_ff     <= '0;
         bval_ff     <= 1'b0;
      end else begin
         start_d1_ff.valid <= start;
         start_d1_ff.row   <= i_ff;
         start_d1_ff.col   <= j_ff;
         start_d1_ff.last  <= last_elem;
         start_d1_ff.sum   <= '0;
         head_ff           <= start_d1_ff;
         bval_ff           <= issue;
      end
   end

   assign bcast.valid = bval_ff;
   assign bcast.tag   = tag_ff;
   assign bcast.a     = a_rd_ff;
   assign bcast.b     = b_rd_ff;

   // The chain: cell k adds term k as the word passes, one cell per cycle.
   assign chain[0] = head_ff;
   for (genvar c = 0; c < DIM_CAP; c++) begin : g_cell
      mme_cell #(
         .CELL_IDX (c)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .bcast     (bcast),
         .inner_dim (nk),
         .prev_word (chain[c]),
         .next_word (chain[c+1])
      );
   end
   assign tail = chain[DIM_CAP];

   // Saturate the wide sum into 32 bits.
   always_comb begin
      fits           = (&tail.sum[SUM_W-1:DATA_W-1]) || !(|tail.sum[SUM_W-1:DATA_W-1]);
      push_word.row  = tail.row;
      push_word.col  = tail.col;
      push_word.last = tail.last;
      if (fits) begin
         push_word.value = tail.sum[DATA_W-1:0];
      end else if (tail.sum[SUM_W-1]) begin
         push_word.value = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         push_word.value = {1'b0, {(DATA_W-1){1'b1}}};
      end
   end

   // Count words in the chain so the request side stays closed until they land.
   assign inflight_in = inflight_ff + INF_W'(start) - INF_W'(tail.valid);

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

   mme_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (tail.valid),
      .push_word (push_word),
      .status    (fifo_status),
      .rsp_ch    (rsp_ch)
   );

   `MME_ASSERT_NEXT(a_compute_starts, clock, reset, accept && req_ch.opcode == OP_COMPUTE, seq_active_ff)
   `MME_ASSERT_NOW(a_no_push_when_full, clock, reset, tail.valid, !fifo_status.full)
   `MME_ASSERT_NOW(a_closed_while_busy, clock, reset, seq_active_ff || tail.valid, !req_ch.ready)
   `MME_ASSERT_NOW(a_word_counted, clock, reset, tail.valid, inflight_ff != '0)
endmodule

// File: tb/tb_top.sv
// Self-checking testbench of matrix_multiply_engine: loads, computes, saturation, dimensions.
// Depends on mme_pkg, matrix_multiply_engine and its mme_req_if / mme_rsp_if interfaces.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import mme_pkg::*;

   localparam logic [1:0] OP_IGNORED = 2'd3;   // spare opcode, must be dropped by the block
   localparam int CYCLE_LIMIT = 600000;
   localparam int SETTLE_CYCLES = 40;           // chain plus queue latency, with margin
   localparam int LONG_HOLD = 500;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [DIM_W-1:0] csr_data;

   mme_req_if req_ch ();
   mme_rsp_if rsp_ch ();

   matrix_multiply_engine dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // Shadow copy of the element stores and dimension registers
   int a_shadow [DIM_LIMIT*DIM_LIMIT];
   int b_shadow [DIM_LIMIT*DIM_LIMIT];
   logic [DIM_W-1:0] rows_reg, inner_reg, cols_reg;

   rsp_word_type pending_words[$];   // product words still owed by the block
   int mismatches = 0;
   int cycles = 0;
   bit calm = 0;          // no idling on either side while set
   bit long_hold = 0;     // ask the receiver for one long hold-off

   typedef struct {
      logic [1:0]  op;
      logic [2:0]  row;
      logic [2:0]  col;
      logic [31:0] value;
      bit          typed;      // expected single word typed in below
      logic [31:0] exp_value;
   } stim_row_type;

   // Dimensions are all 1 here, so every compute gives one word at (0,0), last set
   stim_row_type directed [] = '{
      '{OP_WRITE_A, 3'd0, 3'd0, 32'h7fff_ffff, 0, 32'h0},
      '{OP_WRITE_B, 3'd0, 3'd0, 32'h7fff_ffff, 0, 32'h0},
      '{OP_COMPUTE, 3'd5, 3'd2, 32'h1234_5678, 1, 32'h7fff_ffff},  // overflow high
      '{OP_WRITE_A, 3'd0, 3'd0, 32'h8000_0000, 0, 32'h0},
      '{OP_COMPUTE, 3'd0, 3'd0, 32'h0,         1, 32'h8000_0000},  // overflow low
      '{OP_WRITE_B, 3'd0, 3'd0, 32'h8000_0000, 0, 32'h0},
      '{OP_COMPUTE, 3'd7, 3'd7, 32'hffff_ffff, 1, 32'h7fff_ffff},  // min times min
      '{OP_WRITE_A, 3'd0, 3'd0, 32'h0001_0000, 0, 32'h0},
      '{OP_WRITE_B, 3'd0, 3'd0, 32'hffff_ffff, 0, 32'h0},
      '{OP_COMPUTE, 3'd0, 3'd0, 32'h0,         1, 32'hffff_ffff},  // shift rounds down
      '{OP_WRITE_A, 3'd0, 3'd0, 32'h0000_0001, 0, 32'h0},
      '{OP_COMPUTE, 3'd0, 3'd0, 32'h0,         1, 32'hffff_ffff},  // tiny negative floors
      '{OP_WRITE_B, 3'd0, 3'd0, 32'h0000_0000, 0, 32'h0},
      '{OP_COMPUTE, 3'd0, 3'd0, 32'h0,         1, 32'h0000_0000},
      '{OP_IGNORED, 3'd0, 3'd0, 32'h7fff_ffff, 0, 32'h0},          // spare opcode: no store
      '{OP_COMPUTE, 3'd0, 3'd0, 32'h0,         1, 32'h0000_0000},
      '{OP_WRITE_A, 3'd7, 3'd7, 32'hffff_ffff, 0, 32'h0},
      '{OP_WRITE_B, 3'd7, 3'd7, 32'h8000_0000, 0, 32'h0},
      '{OP_WRITE_A, 3'd0, 3'd0, 32'h0003_8000, 0, 32'h0},
      '{OP_WRITE_B, 3'd0, 3'd0, 32'hfffe_4000, 0, 32'h0},
      '{OP_COMPUTE, 3'd0, 3'd0, 32'h0,         0, 32'h0}
   };

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic int eff_dim(logic [DIM_W-1:0] raw);
      if (raw == 0) return 1;
      if (raw > DIM_LIMIT) return DIM_LIMIT;
      return int'(raw);
   endfunction

   // Work out every word of C = A x B from the shadow stores, row-major
   function automatic void predict_product();
      int nr, nk, nc;
      longint acc;
      rsp_word_type w;
      nr = eff_dim(rows_reg);
      nk = eff_dim(inner_reg);
      nc = eff_dim(cols_reg);
      for (int i = 0; i < nr; i++) begin
         for (int j = 0; j < nc; j++) begin
            acc = 0;
            for (int k = 0; k < nk; k++) begin
               acc += (longint'(a_shadow[i*DIM_LIMIT+k]) *
                       longint'(b_shadow[k*DIM_LIMIT+j])) >>> 16;
            end
            if (acc > 64'sh7fff_ffff) acc = 64'sh7fff_ffff;
            if (acc < -64'sh8000_0000) acc = -64'sh8000_0000;
            w.row = i[IDX_W-1:0];
            w.col = j[IDX_W-1:0];
            w.value = acc[31:0];
            w.last = (i == nr - 1) && (j == nc - 1);
            pending_words.push_back(w);
         end
      end
   endfunction

   // Apply one accepted word to the shadow state
   function automatic void absorb_word(logic [1:0] op, logic [2:0] row, logic [2:0] col,
                                       logic [31:0] value);
      case (op)
         OP_WRITE_A: a_shadow[row*DIM_LIMIT+col] = value;
         OP_WRITE_B: b_shadow[row*DIM_LIMIT+col] = value;
         OP_COMPUTE: predict_product();
         default: ;
      endcase
   endfunction

   function automatic logic [31:0] draw_element();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
         1: return $urandom();
         default: return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
      endcase
   endfunction

   // Offer one word; return once it is accepted. Valid stays high across back-to-back words.
   task automatic send_word(logic [1:0] op, logic [2:0] row, logic [2:0] col,
                            logic [31:0] value);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.opcode <= op;
      req_ch.row_index <= row;
      req_ch.col_index <= col;
      req_ch.element_value <= value;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      absorb_word(op, row, col, value);
   endtask

   // Drop valid, wait for every owed word, then let the chain settle
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_dims(logic [DIM_W-1:0] r, logic [DIM_W-1:0] k, logic [DIM_W-1:0] c);
      csr_we <= 1'b1;
      csr_index <= CSR_ROWS_A;
      csr_data <= r;
      @(posedge clock);
      csr_index <= CSR_INNER_DIM;
      csr_data <= k;
      @(posedge clock);
      csr_index <= CSR_COLS_B;
      csr_data <= c;
      @(posedge clock);
      csr_we <= 1'b0;
      rows_reg = r;
      inner_reg = k;
      cols_reg = c;
   endtask

   // Receiver: draw a stall per word, honour the long hold-off, check each word
   initial begin
      int stall;
      rsp_word_type want;
      rsp_ch.ready <= 1'b0;
      forever begin
         stall = calm ? 0 : $urandom_range(0, 5);
         if (long_hold) begin
            stall = LONG_HOLD;
            long_hold = 0;
         end
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            for (int n = 0; n < stall; n++) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
         if (pending_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected word: row %0d col %0d value %h last %b",
                        rsp_ch.out_row, rsp_ch.out_col, rsp_ch.out_value, rsp_ch.last);
         end else begin
            want = pending_words.pop_front();
            if (rsp_ch.out_row !== want.row || rsp_ch.out_col !== want.col ||
                rsp_ch.out_value !== want.value || rsp_ch.last !== want.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("word mismatch: exp (%0d,%0d) %h last %b, got (%0d,%0d) %h last %b",
                           want.row, want.col, want.value, want.last, rsp_ch.out_row,
                           rsp_ch.out_col, rsp_ch.out_value, rsp_ch.last);
            end
         end
      end
   end

   // Stimulus
   initial begin
      logic [DIM_W-1:0] phase_rows [8] = '{4'd0, 4'd15, 4'd3, 4'd1, 4'd8, 4'd2, 4'd5, 4'd4};
      logic [DIM_W-1:0] phase_inner [8] = '{4'd15, 4'd0, 4'd2, 4'd8, 4'd1, 4'd3, 4'd4, 4'd6};
      logic [DIM_W-1:0] phase_cols [8] = '{4'd1, 4'd2, 4'd15, 4'd0, 4'd3, 4'd8, 4'd2, 4'd5};
      int pick;
      rsp_word_type typed_word;
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= CSR_ROWS_A;
      csr_data <= '0;
      req_ch.valid <= 1'b0;
      req_ch.opcode <= OP_WRITE_A;
      req_ch.row_index <= '0;
      req_ch.col_index <= '0;
      req_ch.element_value <= '0;
      rows_reg = 4'd8;
      inner_reg = 4'd8;
      cols_reg = 4'd8;
      foreach (a_shadow[n]) begin
         a_shadow[n] = 0;
         b_shadow[n] = 0;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_dims(4'd1, 4'd1, 4'd1);

      // Directed table: typed rows replace the predicted word with the one read off
      foreach (directed[n]) begin
         send_word(directed[n].op, directed[n].row, directed[n].col, directed[n].value);
         if (directed[n].typed) begin
            void'(pending_words.pop_back());
            typed_word.row = '0;
            typed_word.col = '0;
            typed_word.value = directed[n].exp_value;
            typed_word.last = 1'b1;
            pending_words.push_back(typed_word);
         end
      end

      // Fill both stores so no later compute reads an unwritten element
      for (int n = 0; n < DIM_LIMIT*DIM_LIMIT; n++) begin
         send_word(OP_WRITE_A, 3'(n / DIM_LIMIT), 3'(n % DIM_LIMIT), draw_element());
         send_word(OP_WRITE_B, 3'(n / DIM_LIMIT), 3'(n % DIM_LIMIT), draw_element());
      end

      // Random phases over a spread of dimensions, extremes and out-of-range among them
      for (int ph = 0; ph < 8; ph++) begin
         drain();
         write_dims(phase_rows[ph], phase_inner[ph], phase_cols[ph]);
         calm = (ph == 3);
         for (int n = 0; n < 30; n++) begin
            pick = $urandom_range(0, 19);
            if (pick < 14)
               send_word(pick[0] ? OP_WRITE_B : OP_WRITE_A, 3'($urandom_range(0, 7)),
                         3'($urandom_range(0, 7)), draw_element());
            else if (pick < 18)
               send_word(OP_COMPUTE, 3'($urandom()), 3'($urandom()), $urandom());
            else
               send_word(OP_IGNORED, 3'($urandom()), 3'($urandom()), $urandom());
         end
         calm = 0;
      end

      // Pressure: hold the receiver off while one full-size result fills the queue; later computes wait
      drain();
      write_dims(4'd8, 4'd2, 4'd8);
      long_hold = 1;
      send_word(OP_COMPUTE, 3'd0, 3'd0, 32'h0);
      send_word(OP_COMPUTE, 3'd0, 3'd0, 32'h0);
      for (int n = 0; n < 6; n++)
         send_word(OP_WRITE_A, 3'($urandom()), 3'($urandom()), draw_element());
      send_word(OP_COMPUTE, 3'd0, 3'd0, 32'h0);

      drain();
      if (mismatches == 0 && pending_words.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule

// File: files.f
+incdir+src
src/mme_pkg.sv
src/mme_req_if.sv
src/mme_rsp_if.sv
src/mme_cell.sv
src/mme_rsp_fifo.sv
src/matrix_multiply_engine.sv
tb/tb_top.sv
